// ----- rtl/core/rrs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrs_pkg
// shared types and constants of the running regression slope block
// ----------------------------------------------------------------------------
package rrs_pkg;

  // fixed field widths
  localparam int unsigned X_W      = 16;
  localparam int unsigned Y_W      = 24;
  localparam int unsigned SLOPE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // running sums, each wraps at its own width
  localparam int unsigned SX_W  = 24;
  localparam int unsigned SY_W  = 32;
  localparam int unsigned SXY_W = 48;
  localparam int unsigned SXX_W = 40;

  // slope scaling register
  localparam int unsigned FRAC_W     = 5;
  localparam int unsigned FRAC_MAX   = 24;
  localparam int unsigned FRAC_RESET = 16;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DEGEN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIFF,
    BK_SIGN,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [1:0]            operation;
    logic [X_W-1:0]        x;
    logic signed [Y_W-1:0] y;
  } in_req_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;
  } out_rsp_t;

  typedef struct packed {
    logic [SX_W-1:0]  sx;
    logic [SY_W-1:0]  sy;
    logic [SXY_W-1:0] sxy;
    logic [SXX_W-1:0] sxx;
  } sums_t;

endpackage

// ----- rtl/core/running_regression_slope.sv -----
// ----------------------------------------------------------------------------
// running_regression_slope
// back part: radix-4 restoring divider (42 steps for the 83-bit scaled
//   numerator at default widths), skipped when the denominator is zero;
//   the front keeps taking requests while it runs, until the queue is full
// reset: count and sums clear, slope_frac_bits returns to 16; no clearing pass
// ----------------------------------------------------------------------------
module running_regression_slope #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned X_BITS     = 16,
  parameter int unsigned Y_BITS     = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rrs_pkg::in_req_t           in_req_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rrs_pkg::out_rsp_t          out_rsp_o,
  // slope_frac_bits write port
  input  logic                       cfg_we_i,
  input  logic [rrs_pkg::FRAC_W-1:0] cfg_wdata_i
);

  // counter wide enough to hold the capacity itself
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned SUM_W = $bits(rrs_pkg::sums_t);
  localparam int unsigned ENT_W = rrs_pkg::STATUS_W + CNT_W + SUM_W;

  // slope scaling register, values above the max act as the max
  logic [rrs_pkg::FRAC_W-1:0] frac_q;
  logic [rrs_pkg::FRAC_W-1:0] frac_eff;

  // front to queue
  logic                       push;
  logic                       full;
  rrs_pkg::status_e           snap_status;
  logic [CNT_W-1:0]           snap_cnt;
  rrs_pkg::sums_t             snap_sums;
  logic [ENT_W-1:0]           q_wdata;

  // queue to back
  logic                       pop;
  logic                       empty;
  logic [ENT_W-1:0]           q_rdata;
  rrs_pkg::status_e           ent_status;
  logic [CNT_W-1:0]           ent_cnt;
  rrs_pkg::sums_t             ent_sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= rrs_pkg::FRAC_W'(rrs_pkg::FRAC_RESET);
    end else if (cfg_we_i) begin
      frac_q <= cfg_wdata_i;
    end
  end

  assign frac_eff = (frac_q > rrs_pkg::FRAC_W'(rrs_pkg::FRAC_MAX)) ?
                    rrs_pkg::FRAC_W'(rrs_pkg::FRAC_MAX) : frac_q;

  // front: stages the request with its products, then applies it to the sums
  // and hands a snapshot of the updated set to the queue
  rrs_front #(
    .MAX_POINTS (MAX_POINTS),
    .X_BITS     (X_BITS),
    .Y_BITS     (Y_BITS),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_req_i      (in_req_i),
    .full_i        (full),
    .push_o        (push),
    .snap_status_o (snap_status),
    .snap_cnt_o    (snap_cnt),
    .snap_sums_o   (snap_sums)
  );

  assign q_wdata = {snap_status, snap_cnt, snap_sums};

  // snapshot queue lets the front keep taking requests while the divider runs
  rrs_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (rrs_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  assign ent_status = rrs_pkg::status_e'(q_rdata[ENT_W-1 -: rrs_pkg::STATUS_W]);
  assign ent_cnt    = q_rdata[SUM_W +: CNT_W];
  assign ent_sums   = q_rdata[SUM_W-1:0];

  // back: products, numerator and denominator, divide, output register
  rrs_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .pop_o        (pop),
    .ent_status_i (ent_status),
    .ent_cnt_i    (ent_cnt),
    .ent_sums_i   (ent_sums),
    .frac_i       (frac_eff),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

// ----- rtl/core/rrs_front.sv -----
// ----------------------------------------------------------------------------
// rrs_front
// takes requests, forms point products and updates count and running sums
// ----------------------------------------------------------------------------
module rrs_front #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned X_BITS     = 16,
  parameter int unsigned Y_BITS     = 24,
  parameter int unsigned CNT_W      = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rrs_pkg::in_req_t     in_req_i,
  input  logic                 full_i,
  output logic                 push_o,
  output rrs_pkg::status_e     snap_status_o,
  output logic [CNT_W-1:0]     snap_cnt_o,
  output rrs_pkg::sums_t       snap_sums_o
);

  localparam int unsigned XB    = (X_BITS < rrs_pkg::X_W) ? X_BITS : rrs_pkg::X_W;
  localparam int unsigned YB    = (Y_BITS < rrs_pkg::Y_W) ? Y_BITS : rrs_pkg::Y_W;
  localparam int unsigned XY_W  = rrs_pkg::X_W + rrs_pkg::Y_W;
  localparam int unsigned XX_W  = 2 * rrs_pkg::X_W;

  logic                              stg_vld_q, stg_vld_d;
  logic [1:0]                        stg_op_q;
  logic [rrs_pkg::X_W-1:0]           stg_x_q;
  logic signed [rrs_pkg::Y_W-1:0]    stg_y_q;
  logic signed [XY_W-1:0]            stg_xy_q;
  logic [XX_W-1:0]                   stg_xx_q;

  logic [rrs_pkg::X_W-1:0]           x_eff;
  logic signed [rrs_pkg::Y_W-1:0]    y_ext;
  logic signed [XY_W-1:0]            xy_d;
  logic [XX_W-1:0]                   xx_d;
  logic                              accept;

  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  rrs_pkg::sums_t                    sums_q, sums_d;
  rrs_pkg::status_e                  st_d;
  logic [rrs_pkg::SX_W-1:0]          dx;
  logic [rrs_pkg::SY_W-1:0]          dy;
  logic [rrs_pkg::SXY_W-1:0]         dxy;
  logic [rrs_pkg::SXX_W-1:0]         dxx;

  // only the low X_BITS of x count, y is sign-extended from Y_BITS
  always_comb begin
    for (int i = 0; i < int'(rrs_pkg::X_W); i++) begin
      x_eff[i] = (i < int'(XB)) ? in_req_i.x[i] : 1'b0;
    end
    for (int i = 0; i < int'(rrs_pkg::Y_W); i++) begin
      y_ext[i] = (i < int'(YB)) ? in_req_i.y[i] : in_req_i.y[YB-1];
    end
    xy_d = $signed({1'b0, x_eff}) * y_ext;
    xx_d = x_eff * x_eff;
  end

  assign push_o     = stg_vld_q && !full_i;
  assign in_stall_o = stg_vld_q && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (accept) begin
      stg_vld_d = 1'b1;
    end else if (push_o) begin
      stg_vld_d = 1'b0;
    end else begin
      stg_vld_d = stg_vld_q;
    end
  end

  // sum update for the staged request
  always_comb begin
    dx     = rrs_pkg::SX_W'(stg_x_q);
    dy     = rrs_pkg::SY_W'(stg_y_q);
    dxy    = rrs_pkg::SXY_W'(stg_xy_q);
    dxx    = rrs_pkg::SXX_W'(stg_xx_q);
    sums_d = sums_q;
    cnt_d  = cnt_q;
    st_d   = rrs_pkg::ST_OK;
    case (stg_op_q)
      rrs_pkg::OP_ADD: begin
        if (cnt_q == CNT_W'(MAX_POINTS)) begin
          st_d = rrs_pkg::ST_FULL;
        end else begin
          sums_d.sx  = sums_q.sx + dx;
          sums_d.sy  = sums_q.sy + dy;
          sums_d.sxy = sums_q.sxy + dxy;
          sums_d.sxx = sums_q.sxx + dxx;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      rrs_pkg::OP_REMOVE: begin
        if (cnt_q == '0) begin
          st_d = rrs_pkg::ST_EMPTY;
        end else begin
          sums_d.sx  = sums_q.sx - dx;
          sums_d.sy  = sums_q.sy - dy;
          sums_d.sxy = sums_q.sxy - dxy;
          sums_d.sxx = sums_q.sxx - dxx;
          cnt_d      = cnt_q - 1'b1;
        end
      end
      rrs_pkg::OP_CLEAR: begin
        sums_d = '0;
        cnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  assign snap_status_o = st_d;
  assign snap_cnt_o    = cnt_d;
  assign snap_sums_o   = sums_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      cnt_q     <= '0;
      sums_q    <= '0;
    end else begin
      stg_vld_q <= stg_vld_d;
      if (push_o) begin
        cnt_q  <= cnt_d;
        sums_q <= sums_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_op_q <= in_req_i.operation;
      stg_x_q  <= x_eff;
      stg_y_q  <= y_ext;
      stg_xy_q <= xy_d;
      stg_xx_q <= xx_d;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");

endmodule

// ----- rtl/core/rrs_fifo.sv -----
// ----------------------------------------------------------------------------
// rrs_fifo
// short queue of sum snapshots between front and back
// ----------------------------------------------------------------------------
module rrs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/rrs_divider.sv -----
// ----------------------------------------------------------------------------
// rrs_divider
// restoring divider, two quotient bits per cycle, saturating 32-bit result
// ----------------------------------------------------------------------------
module rrs_divider #(
  parameter int unsigned AN_W = 59,
  parameter int unsigned AD_W = 50
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [AN_W-1:0]             an_i,
  input  logic [AD_W-1:0]             ad_i,
  input  logic [rrs_pkg::FRAC_W-1:0]  frac_i,
  input  logic                        neg_i,
  output logic                        done_o,
  output logic [rrs_pkg::SLOPE_W-1:0] slope_o
);

  localparam int unsigned DVD_W  = AN_W + rrs_pkg::FRAC_MAX;
  localparam int unsigned STEPS  = (DVD_W + 1) / 2;
  localparam int unsigned DR_W   = 2 * STEPS;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);
  localparam int unsigned Q_W    = rrs_pkg::SLOPE_W + 1;
  localparam logic [Q_W-1:0] LIM_NEG = Q_W'(1) << (rrs_pkg::SLOPE_W - 1);
  localparam logic [Q_W-1:0] LIM_POS = LIM_NEG - 1'b1;

  logic              busy_q, busy_d;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DR_W-1:0]   dvd_q;
  logic [AD_W-1:0]   rem_q;
  logic [AD_W-1:0]   ad_q;
  logic [Q_W-1:0]    quo_q;
  logic              ovf_q;
  logic              neg_q;

  logic [AD_W:0]     r1, r1_sub, r2, r2_sub;
  logic [AD_W-1:0]   r1_n, r2_n;
  logic              b1, b2;
  logic              last;
  logic [Q_W-1:0]    lim, mag;
  logic              sat;

  // two restoring steps per cycle
  always_comb begin
    r1     = {rem_q, dvd_q[DR_W-1]};
    r1_sub = r1 - {1'b0, ad_q};
    b1     = (r1 >= {1'b0, ad_q});
    r1_n   = b1 ? r1_sub[AD_W-1:0] : r1[AD_W-1:0];
    r2     = {r1_n, dvd_q[DR_W-2]};
    r2_sub = r2 - {1'b0, ad_q};
    b2     = (r2 >= {1'b0, ad_q});
    r2_n   = b2 ? r2_sub[AD_W-1:0] : r2[AD_W-1:0];
  end

  assign last = busy_q && (step_q == STEP_W'(1));

  always_comb begin
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= last;
      if (start_i) begin
        step_q <= STEP_W'(STEPS);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= DR_W'(an_i) << frac_i;
      rem_q <= '0;
      ad_q  <= ad_i;
      quo_q <= '0;
      ovf_q <= 1'b0;
      neg_q <= neg_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DR_W-3:0], 2'b00};
      rem_q <= r2_n;
      quo_q <= {quo_q[Q_W-3:0], b1, b2};
      // any bit pushed out of the top means the quotient is past the limit
      ovf_q <= ovf_q || (|quo_q[Q_W-1:Q_W-2]);
    end
  end

  // saturate and apply sign
  always_comb begin
    lim     = neg_q ? LIM_NEG : LIM_POS;
    sat     = ovf_q || (quo_q > lim);
    mag     = sat ? lim : quo_q;
    slope_o = neg_q ? -mag[rrs_pkg::SLOPE_W-1:0] : mag[rrs_pkg::SLOPE_W-1:0];
  end

  assign done_o = done_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_pos_not_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !neg_q) |-> !slope_o[rrs_pkg::SLOPE_W-1])
    else $error("positive slope came out negative");

endmodule

// ----- rtl/core/rrs_back.sv -----
// ----------------------------------------------------------------------------
// rrs_back
// turns a sum snapshot into numerator, denominator and the saturated slope
// ----------------------------------------------------------------------------
module rrs_back #(
  parameter int unsigned CNT_W = 9
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  rrs_pkg::status_e           ent_status_i,
  input  logic [CNT_W-1:0]           ent_cnt_i,
  input  rrs_pkg::sums_t             ent_sums_i,
  input  logic [rrs_pkg::FRAC_W-1:0] frac_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rrs_pkg::out_rsp_t          out_rsp_o
);

  localparam int unsigned P1_W   = CNT_W + 1 + rrs_pkg::SXY_W;
  localparam int unsigned P2_W   = rrs_pkg::SX_W + 1 + rrs_pkg::SY_W;
  localparam int unsigned P3_W   = CNT_W + rrs_pkg::SXX_W;
  localparam int unsigned P4_W   = 2 * rrs_pkg::SX_W;
  localparam int unsigned NUM_W  = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int unsigned DEN_W  = ((P3_W > P4_W) ? P3_W : P4_W) + 1;

  rrs_pkg::back_state_e state_q, state_d;

  rrs_pkg::sums_t                   e_sums_q;
  logic [CNT_W-1:0]                 e_cnt_q;
  rrs_pkg::status_e                 e_st_q;

  logic signed [P1_W-1:0]           p1_q, p1_d;
  logic signed [P2_W-1:0]           p2_q, p2_d;
  logic [P3_W-1:0]                  p3_q, p3_d;
  logic [P4_W-1:0]                  p4_q, p4_d;
  logic signed [NUM_W-1:0]          num_q, num_d;
  logic signed [DEN_W-1:0]          den_q, den_d;

  logic [NUM_W-1:0]                 an;
  logic [DEN_W-1:0]                 ad;
  logic                             neg;
  logic                             den_zero;

  logic                             div_start;
  logic                             div_done;
  logic [rrs_pkg::SLOPE_W-1:0]      div_slope;

  logic [rrs_pkg::SLOPE_W-1:0]      res_slope_q;
  rrs_pkg::status_e                 res_st_q;
  logic                             load_out;
  logic                             take;
  logic                             out_vld_q, out_vld_d;
  rrs_pkg::out_rsp_t                out_q;

  always_comb begin
    p1_d  = $signed({1'b0, e_cnt_q}) * $signed(e_sums_q.sxy);
    p2_d  = $signed({1'b0, e_sums_q.sx}) * $signed(e_sums_q.sy);
    p3_d  = e_cnt_q * e_sums_q.sxx;
    p4_d  = e_sums_q.sx * e_sums_q.sx;
    num_d = NUM_W'(p1_q) - NUM_W'(p2_q);
    den_d = $signed(DEN_W'(p3_q)) - $signed(DEN_W'(p4_q));
  end

  // magnitudes, sign of the quotient folded from both operands
  always_comb begin
    an       = num_q[NUM_W-1] ? -num_q : num_q;
    ad       = den_q[DEN_W-1] ? -den_q : den_q;
    neg      = num_q[NUM_W-1] ^ den_q[DEN_W-1];
    den_zero = (den_q == '0);
  end

  assign take = out_vld_q && !out_stall_i;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      rrs_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = rrs_pkg::BK_MUL;
        end
      end
      rrs_pkg::BK_MUL: begin
        state_d = rrs_pkg::BK_DIFF;
      end
      rrs_pkg::BK_DIFF: begin
        state_d = rrs_pkg::BK_SIGN;
      end
      rrs_pkg::BK_SIGN: begin
        if (den_zero) begin
          state_d = rrs_pkg::BK_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = rrs_pkg::BK_DIV;
        end
      end
      rrs_pkg::BK_DIV: begin
        if (div_done) begin
          state_d = rrs_pkg::BK_DONE;
        end
      end
      rrs_pkg::BK_DONE: begin
        if (!out_vld_q || take) begin
          load_out = 1'b1;
          state_d  = rrs_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rrs_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrs_pkg::BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      e_sums_q <= ent_sums_i;
      e_cnt_q  <= ent_cnt_i;
      e_st_q   <= ent_status_i;
    end
    if (state_q == rrs_pkg::BK_MUL) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
      p4_q <= p4_d;
    end
    if (state_q == rrs_pkg::BK_DIFF) begin
      num_q <= num_d;
      den_q <= den_d;
    end
    if ((state_q == rrs_pkg::BK_SIGN) && den_zero) begin
      res_slope_q <= '0;
      res_st_q    <= (e_st_q == rrs_pkg::ST_OK) ? rrs_pkg::ST_DEGEN : e_st_q;
    end else if ((state_q == rrs_pkg::BK_DIV) && div_done) begin
      res_slope_q <= div_slope;
      res_st_q    <= e_st_q;
    end
    if (load_out) begin
      out_q.slope  <= res_slope_q;
      out_q.status <= res_st_q;
      out_q.count  <= rrs_pkg::COUNT_W'(e_cnt_q);
    end
  end

  rrs_divider #(
    .AN_W (NUM_W),
    .AD_W (DEN_W)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .an_i    (an),
    .ad_i    (ad),
    .frac_i  (frac_i),
    .neg_i   (neg),
    .done_o  (div_done),
    .slope_o (div_slope)
  );

  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == rrs_pkg::BK_DIV))
    else $error("divider result outside divide state");

endmodule
